FILE: rtl/cfdl_pkg.sv
// ----------------------------------------------------------------------------
// cfdl_pkg
// Shared widths, constants and types of the crossfading lookahead delay line.
// ----------------------------------------------------------------------------
package cfdl_pkg;

  // Ring geometry (power of two, so tap addresses wrap by truncation)
  localparam int DEPTH    = 8192;
  localparam int ADDR_W   = $clog2(DEPTH);

  // Field widths
  localparam int SAMPLE_W = 24;
  localparam int LEVEL_W  = 16;
  localparam int REQ_W    = 13;
  localparam int LEN_W    = 11;
  localparam int RECIP_W  = 17;

  // Crossfade progress, Q1.16 saturated to 0..1.0
  localparam int PROG_FRAC = 16;
  localparam int PROG_W    = PROG_FRAC + 1;
  localparam int PROG_MAX  = 1 << PROG_FRAC;

  // Reset values
  localparam logic signed [LEVEL_W-1:0] LEVEL_RESET = -16'sd25600;
  localparam logic [LEN_W-1:0]          LEN_RESET   = 11'd384;
  localparam logic [RECIP_W-1:0]        RECIP_RESET = 17'd171;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_RECIPROCAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE             = 2'd2;

  // Result buffer
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [LEVEL_W-1:0]  level_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [REQ_W-1:0]           delay_t;
  typedef logic [PROG_W-1:0]          prog_t;

  // One ring entry: both samples and the level
  typedef struct packed {
    sample_t left;
    sample_t right;
    level_t  level;
  } tap_t;

  // Per-item control that travels with the datapath
  typedef struct packed {
    logic   active;
    logic   mono;
    delay_t delay;
  } meta_t;

  typedef struct packed {
    sample_t delayed_left;
    sample_t delayed_right;
    level_t  aligned_level_db;
    logic    transition_active;
    delay_t  delay_in_use;
  } result_t;

endpackage

FILE: rtl/cfdl_if.sv
// ----------------------------------------------------------------------------
// cfdl_if
// Handshake channels of the delay line: input items, results, configuration.
// ----------------------------------------------------------------------------
interface cfdl_in_if;
  logic                     valid;
  logic                     ready;
  cfdl_pkg::sample_t        left_sample;
  cfdl_pkg::sample_t        right_sample;
  cfdl_pkg::level_t         level_db;
  cfdl_pkg::delay_t         requested_delay;

  modport source (output valid, output left_sample, output right_sample,
                  output level_db, output requested_delay, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input level_db, input requested_delay, output ready);
endinterface

interface cfdl_out_if;
  logic                     valid;
  logic                     ready;
  cfdl_pkg::sample_t        delayed_left;
  cfdl_pkg::sample_t        delayed_right;
  cfdl_pkg::level_t         aligned_level_db;
  logic                     transition_active;
  cfdl_pkg::delay_t         delay_in_use;

  modport source (output valid, output delayed_left, output delayed_right,
                  output aligned_level_db, output transition_active,
                  output delay_in_use, input ready);
  modport sink   (input valid, input delayed_left, input delayed_right,
                  input aligned_level_db, input transition_active,
                  input delay_in_use, output ready);
endinterface

interface cfdl_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cfdl_pkg::CFG_IDX_W-1:0]      index;
  logic [cfdl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cfdl_ring.sv
// ----------------------------------------------------------------------------
// cfdl_ring
// Ring memory holding left, right and level per entry; one write port and
// one read port, read data registered.
// ----------------------------------------------------------------------------
module cfdl_ring (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  cfdl_pkg::addr_t       wr_addr_i,
  input  cfdl_pkg::tap_t        wr_data_i,
  input  logic                  rd_en_i,
  input  cfdl_pkg::addr_t       rd_addr_i,
  output cfdl_pkg::tap_t        rd_data_o
);

  cfdl_pkg::tap_t mem_q [cfdl_pkg::DEPTH];
  cfdl_pkg::tap_t rd_data_q;

  // Write the entry of the item in flight
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one tap, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/cfdl_blend.sv
// ----------------------------------------------------------------------------
// cfdl_blend
// Two-stage linear crossfade: difference times progress, then floor shift
// and add to the current tap; mono copy of left onto right.
// ----------------------------------------------------------------------------
module cfdl_blend (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  cfdl_pkg::tap_t        cur_i,
  input  cfdl_pkg::tap_t        tgt_i,
  input  cfdl_pkg::prog_t       prog_i,
  input  cfdl_pkg::meta_t       meta_i,
  output logic                  valid_o,
  output cfdl_pkg::result_t     result_o
);

  localparam int SDIFF_W = cfdl_pkg::SAMPLE_W + 1;
  localparam int SPROD_W = SDIFF_W + cfdl_pkg::PROG_W + 1;
  localparam int LDIFF_W = cfdl_pkg::LEVEL_W + 1;
  localparam int LPROD_W = LDIFF_W + cfdl_pkg::PROG_W + 1;

  logic signed [cfdl_pkg::PROG_W:0] prog_s;
  logic signed [SDIFF_W-1:0]        diff_l, diff_r;
  logic signed [LDIFF_W-1:0]        diff_v;
  logic signed [SPROD_W-1:0]        prod_l, prod_r;
  logic signed [LPROD_W-1:0]        prod_v;

  logic                             a_valid_q;
  cfdl_pkg::tap_t                   a_cur_q;
  cfdl_pkg::meta_t                  a_meta_q;
  logic signed [SPROD_W-1:0]        a_prod_l_q, a_prod_r_q;
  logic signed [LPROD_W-1:0]        a_prod_v_q;

  logic signed [SPROD_W-1:0]        sum_l, sum_r;
  logic signed [LPROD_W-1:0]        sum_v;
  cfdl_pkg::result_t                res_d, res_q;
  logic                             res_valid_q;

  // Stage A: tap differences scaled by progress
  always_comb begin
    prog_s = $signed({1'b0, prog_i});
    diff_l = $signed({tgt_i.left[cfdl_pkg::SAMPLE_W-1], tgt_i.left})
           - $signed({cur_i.left[cfdl_pkg::SAMPLE_W-1], cur_i.left});
    diff_r = $signed({tgt_i.right[cfdl_pkg::SAMPLE_W-1], tgt_i.right})
           - $signed({cur_i.right[cfdl_pkg::SAMPLE_W-1], cur_i.right});
    diff_v = $signed({tgt_i.level[cfdl_pkg::LEVEL_W-1], tgt_i.level})
           - $signed({cur_i.level[cfdl_pkg::LEVEL_W-1], cur_i.level});
    prod_l = SPROD_W'(diff_l) * SPROD_W'(prog_s);
    prod_r = SPROD_W'(diff_r) * SPROD_W'(prog_s);
    prod_v = LPROD_W'(diff_v) * LPROD_W'(prog_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      a_cur_q    <= cur_i;
      a_meta_q   <= meta_i;
      a_prod_l_q <= prod_l;
      a_prod_r_q <= prod_r;
      a_prod_v_q <= prod_v;
    end
  end

  // Stage B: floor to Q0 and add to the current tap
  always_comb begin
    sum_l = SPROD_W'(a_cur_q.left)  + (a_prod_l_q >>> cfdl_pkg::PROG_FRAC);
    sum_r = SPROD_W'(a_cur_q.right) + (a_prod_r_q >>> cfdl_pkg::PROG_FRAC);
    sum_v = LPROD_W'(a_cur_q.level) + (a_prod_v_q >>> cfdl_pkg::PROG_FRAC);
    res_d.delayed_left      = sum_l[cfdl_pkg::SAMPLE_W-1:0];
    res_d.delayed_right     = a_meta_q.mono ? sum_l[cfdl_pkg::SAMPLE_W-1:0]
                                            : sum_r[cfdl_pkg::SAMPLE_W-1:0];
    res_d.aligned_level_db  = sum_v[cfdl_pkg::LEVEL_W-1:0];
    res_d.transition_active = a_meta_q.active;
    res_d.delay_in_use      = a_meta_q.delay;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o  = res_valid_q;
  assign result_o = res_q;

endmodule

FILE: rtl/crossfading_lookahead_delay_line_top.sv
// ----------------------------------------------------------------------------
// crossfading_lookahead_delay_line_top
// Variable lookahead delay line with linear crossfade between delay taps.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-------------------------------------------
//   cfg_i    | in  | valid / ready | index, data (length, reciprocal, mono)
//   in_i     | in  | valid / ready | left, right, level, requested delay
//   out_o    | out | valid / ready | delayed pair, aligned level, active, delay
//
// Input is taken only when no target read is pending: each item reads two
// taps (current and target) from the ring memory, which has a single read port.
// A result passes stage 1, stage 2 and blend stages A and B before it is buffered.
// Reset: no clearing pass; the write pointer and a wrap flag mark which ring
// entries were written, and unwritten entries read as zero samples and -100 dB.
// Stalls: up to 4 results are held; input stops while 4 are outstanding.
// ----------------------------------------------------------------------------
module crossfading_lookahead_delay_line_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfdl_cfg_if.sink      cfg_i,
  cfdl_in_if.sink       in_i,
  cfdl_out_if.source    out_o
);

  // Configuration registers
  logic [cfdl_pkg::LEN_W-1:0]   len_q;
  logic [cfdl_pkg::RECIP_W-1:0] recip_q;
  logic                         mono_q;

  // Delay state
  cfdl_pkg::addr_t              wi_q;
  logic                         wrapped_q;
  cfdl_pkg::addr_t              cur_q, tgt_q;
  logic [cfdl_pkg::LEN_W-1:0]   rem_q;

  // Accept-time decisions
  logic                         in_fire, cfg_fire;
  cfdl_pkg::addr_t              req_sat, tgt_n, ci, ti;
  logic [cfdl_pkg::LEN_W-1:0]   len_eff, rem_n, rem_dec;
  logic                         start, active;
  logic signed [cfdl_pkg::LEN_W:0]                      elapsed;
  logic signed [cfdl_pkg::LEN_W+cfdl_pkg::RECIP_W+1:0]  pprod, praw;
  cfdl_pkg::prog_t              prog;

  // Stage 1 (second memory cycle)
  logic                         phase_q;
  cfdl_pkg::tap_t               s1_in_q;
  cfdl_pkg::addr_t              s1_wi_q, s1_ti_q;
  logic                         s1_cfwd_q, s1_cval_q, s1_tfwd_q, s1_tval_q;
  cfdl_pkg::prog_t              s1_prog_q;
  cfdl_pkg::meta_t              s1_meta_q;

  // Stage 2 (target data returns)
  logic                         s2_valid_q;
  cfdl_pkg::tap_t               s2_cur_q, s2_in_q;
  logic                         s2_tfwd_q, s2_tval_q;
  cfdl_pkg::prog_t              s2_prog_q;
  cfdl_pkg::meta_t              s2_meta_q;

  // Memory and blend
  logic                         rd_en;
  cfdl_pkg::addr_t              rd_addr;
  cfdl_pkg::tap_t               rd_data, cur_tap, tgt_tap;
  logic                         res_valid;
  cfdl_pkg::result_t            res;

  // Result buffer
  cfdl_pkg::result_t            fifo_q [cfdl_pkg::FIFO_DEPTH];
  logic [cfdl_pkg::FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [cfdl_pkg::FIFO_CNT_W-1:0] fifo_cnt_q, resv_q;
  logic                         out_fire;

  // Select a tap: fresh input samples on the write slot, reset value if never written
  function automatic cfdl_pkg::tap_t pick_tap(cfdl_pkg::tap_t mem, cfdl_pkg::tap_t fresh,
                                              logic fwd, logic written);
    cfdl_pkg::tap_t t;
    t.left  = fwd ? fresh.left  : (written ? mem.left  : '0);
    t.right = fwd ? fresh.right : (written ? mem.right : '0);
    t.level = written ? mem.level : cfdl_pkg::LEVEL_RESET;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= cfdl_pkg::LEN_RESET;
      recip_q <= cfdl_pkg::RECIP_RESET;
      mono_q  <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        cfdl_pkg::CFG_TRANSITION_LENGTH:     len_q   <= cfg_i.data[cfdl_pkg::LEN_W-1:0];
        cfdl_pkg::CFG_TRANSITION_RECIPROCAL: recip_q <= cfg_i.data[cfdl_pkg::RECIP_W-1:0];
        cfdl_pkg::CFG_MONO_MODE:             mono_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Request check, tap addresses and progress at acceptance
  // --------------------------------------------------------------------------
  assign in_i.ready = !phase_q && (resv_q != cfdl_pkg::FIFO_CNT_W'(cfdl_pkg::FIFO_DEPTH));
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    if (32'(in_i.requested_delay) > cfdl_pkg::DEPTH - 1) begin
      req_sat = cfdl_pkg::ADDR_W'(cfdl_pkg::DEPTH - 1);
    end else begin
      req_sat = cfdl_pkg::ADDR_W'(in_i.requested_delay);
    end
    len_eff = (len_q == '0) ? cfdl_pkg::LEN_W'(1) : len_q;
    start   = (rem_q == '0) && (req_sat != tgt_q);
    tgt_n   = start ? req_sat : tgt_q;
    rem_n   = start ? len_eff : rem_q;
    rem_dec = rem_n - cfdl_pkg::LEN_W'(1);
    active  = (rem_n != '0);
    ci      = wi_q - cur_q;
    ti      = wi_q - tgt_n;

    // progress = floor(elapsed * recip / 2^16), held to 0..1.0
    elapsed = $signed({1'b0, len_eff}) - $signed({1'b0, rem_n});
    pprod   = $bits(pprod)'(elapsed) * $signed({{($bits(pprod)-cfdl_pkg::RECIP_W){1'b0}},
                                                 recip_q});
    praw    = pprod >>> cfdl_pkg::PROG_FRAC;
    if (!active || praw < 0) begin
      prog = '0;
    end else if (praw > $signed($bits(praw)'(cfdl_pkg::PROG_MAX))) begin
      prog = cfdl_pkg::PROG_W'(cfdl_pkg::PROG_MAX);
    end else begin
      prog = praw[cfdl_pkg::PROG_W-1:0];
    end
  end

  // Advance delay state once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q      <= '0;
      wrapped_q <= 1'b0;
      cur_q     <= '0;
      tgt_q     <= '0;
      rem_q     <= '0;
    end else if (in_fire) begin
      wi_q  <= wi_q + cfdl_pkg::ADDR_W'(1);
      tgt_q <= tgt_n;
      if (wi_q == cfdl_pkg::ADDR_W'(cfdl_pkg::DEPTH - 1)) begin
        wrapped_q <= 1'b1;
      end
      if (active) begin
        rem_q <= rem_dec;
        if (rem_dec == '0) begin
          cur_q <= tgt_n;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: hold the item for its second memory cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
    end else begin
      phase_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_in_q.left   <= in_i.left_sample;
      s1_in_q.right  <= in_i.right_sample;
      s1_in_q.level  <= in_i.level_db;
      s1_wi_q        <= wi_q;
      s1_ti_q        <= ti;
      s1_cfwd_q      <= (ci == wi_q);
      s1_cval_q      <= wrapped_q || (ci < wi_q);
      s1_tfwd_q      <= (ti == wi_q);
      s1_tval_q      <= wrapped_q || (ti < wi_q);
      s1_prog_q      <= prog;
      s1_meta_q.active <= active;
      s1_meta_q.mono   <= mono_q;
      s1_meta_q.delay  <= cfdl_pkg::REQ_W'(tgt_n);
    end
  end

  // --------------------------------------------------------------------------
  // Ring memory: current tap on acceptance, target tap and write next cycle
  // --------------------------------------------------------------------------
  assign rd_en   = in_fire || phase_q;
  assign rd_addr = phase_q ? s1_ti_q : ci;

  cfdl_ring u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (phase_q),
    .wr_addr_i (s1_wi_q),
    .wr_data_i (s1_in_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign cur_tap = pick_tap(rd_data, s1_in_q, s1_cfwd_q, s1_cval_q);
  assign tgt_tap = pick_tap(rd_data, s2_in_q, s2_tfwd_q, s2_tval_q);

  // --------------------------------------------------------------------------
  // Stage 2: current tap captured, target tap arriving
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= phase_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q) begin
      s2_cur_q  <= cur_tap;
      s2_in_q   <= s1_in_q;
      s2_tfwd_q <= s1_tfwd_q;
      s2_tval_q <= s1_tval_q;
      s2_prog_q <= s1_prog_q;
      s2_meta_q <= s1_meta_q;
    end
  end

  cfdl_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid_q),
    .cur_i    (s2_cur_q),
    .tgt_i    (tgt_tap),
    .prog_i   (s2_prog_q),
    .meta_i   (s2_meta_q),
    .valid_o  (res_valid),
    .result_o (res)
  );

  // --------------------------------------------------------------------------
  // Result buffer: slots are reserved at acceptance, so pushes never overflow
  // --------------------------------------------------------------------------
  assign out_fire = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= '0;
      rptr_q     <= '0;
      fifo_cnt_q <= '0;
      resv_q     <= '0;
    end else begin
      if (res_valid) begin
        wptr_q <= wptr_q + cfdl_pkg::FIFO_PTR_W'(1);
      end
      if (out_fire) begin
        rptr_q <= rptr_q + cfdl_pkg::FIFO_PTR_W'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + cfdl_pkg::FIFO_CNT_W'(res_valid)
                               - cfdl_pkg::FIFO_CNT_W'(out_fire);
      resv_q     <= resv_q + cfdl_pkg::FIFO_CNT_W'(in_fire)
                           - cfdl_pkg::FIFO_CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      fifo_q[wptr_q] <= res;
    end
  end

  assign out_o.valid             = (fifo_cnt_q != '0);
  assign out_o.delayed_left      = fifo_q[rptr_q].delayed_left;
  assign out_o.delayed_right     = fifo_q[rptr_q].delayed_right;
  assign out_o.aligned_level_db  = fifo_q[rptr_q].aligned_level_db;
  assign out_o.transition_active = fifo_q[rptr_q].transition_active;
  assign out_o.delay_in_use      = fifo_q[rptr_q].delay_in_use;

`ifndef SYNTHESIS
  a_resv_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resv_q <= cfdl_pkg::FIFO_CNT_W'(cfdl_pkg::FIFO_DEPTH))
    else $error("result reservations exceed buffer depth");

  a_fifo_in_resv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= resv_q)
    else $error("buffered results exceed reservations");

  a_idle_delays_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q == '0) |-> (cur_q == tgt_q))
    else $error("current and target delay differ with no crossfade running");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ##4 res_valid)
    else $error("result did not leave the blend four cycles after acceptance");
`endif

endmodule

FILE: sim/crossfading_lookahead_delay_line_top_test.sv
// ----------------------------------------------------------------------------
// crossfading_lookahead_delay_line_top_test
// Drives stereo items through the delay line under random source gaps and sink
// stalls. A short table of hand-picked items comes first, some rows with their
// result typed in. Twelve random phases follow, each with its own crossfade
// length, reciprocal and mono setting. Every result is compared field by
// field with its typed result or a cycle-free model of rings, taps and crossfade.
// ----------------------------------------------------------------------------
module crossfading_lookahead_delay_line_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cfdl_pkg::*;

  // Index past the last register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 12;
  localparam int QUIET_LIMIT   = 1000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;

  typedef struct packed {
    sample_t left;
    sample_t right;
    level_t  level;
    delay_t  req;
  } item_t;

  typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_e;

  // One row of the directed table: a register write or an item
  typedef struct packed {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    item_t                 it;
    logic                  typed;
    result_t               want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;
  bit   idle_on;
  bit   stalls_on;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;

  // Predicted state of the delay line
  sample_t            ring_l   [DEPTH];
  sample_t            ring_r   [DEPTH];
  level_t             ring_lvl [DEPTH];
  addr_t              wr_ptr;
  delay_t             cur_delay;
  delay_t             tgt_delay;
  logic [LEN_W-1:0]   fade_left;
  logic [LEN_W-1:0]   fade_len;
  logic [RECIP_W-1:0] recip;
  logic               mono;

  delay_t  want_delay;
  result_t delayed_q [$];
  step_t   plan [$];

  cfdl_cfg_if cfg_if ();
  cfdl_in_if  in_if ();
  cfdl_out_if out_if ();

  assign out_if.ready = sink_ready;

  crossfading_lookahead_delay_line_top i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Linear blend from one tap towards the other, Q1.16 progress, floor
  function automatic longint mix(input longint from_tap, input longint to_tap,
                                 input longint prog);
    return from_tap + (((to_tap - from_tap) * prog) >>> PROG_FRAC);
  endfunction

  // Advance the predicted delay line by one item and return its result
  function automatic result_t run_delay_line(input item_t it);
    result_t          r;
    logic [LEN_W-1:0] span;
    addr_t            now_tap;
    addr_t            next_tap;
    longint           prog;
    logic             fading;
    span = (fade_len == '0) ? LEN_W'(1) : fade_len;
    // take a new request only between crossfades
    if (fade_left == '0 && it.req != tgt_delay) begin
      tgt_delay = it.req;
      fade_left = span;
    end
    ring_l[wr_ptr] = it.left;
    ring_r[wr_ptr] = it.right;
    now_tap = wr_ptr - addr_t'(cur_delay);
    r.delayed_left     = ring_l[now_tap];
    r.delayed_right    = ring_r[now_tap];
    r.aligned_level_db = ring_lvl[now_tap];
    fading = (fade_left != '0);
    if (fading) begin
      next_tap = wr_ptr - addr_t'(tgt_delay);
      prog = ((longint'(span) - longint'(fade_left)) * longint'(recip)) >>> PROG_FRAC;
      // clamp, e.g. after the length was shortened mid-crossfade
      if (prog < 0) prog = 0;
      if (prog > PROG_MAX) prog = PROG_MAX;
      r.delayed_left     = sample_t'(mix(ring_l[now_tap], ring_l[next_tap], prog));
      r.delayed_right    = sample_t'(mix(ring_r[now_tap], ring_r[next_tap], prog));
      r.aligned_level_db = level_t'(mix(ring_lvl[now_tap], ring_lvl[next_tap], prog));
    end
    // level is read before it is overwritten
    ring_lvl[wr_ptr] = it.level;
    if (fading) begin
      fade_left--;
      if (fade_left == '0) cur_delay = tgt_delay;
    end
    wr_ptr++;
    if (mono) r.delayed_right = r.delayed_left;
    r.transition_active = fading;
    r.delay_in_use      = tgt_delay;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_TRANSITION_LENGTH:     fade_len = val[LEN_W-1:0];
      CFG_TRANSITION_RECIPROCAL: recip = val[RECIP_W-1:0];
      CFG_MONO_MODE:             mono = val[0];
      default: ;
    endcase
  endfunction

  function automatic step_t cfg_step(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    step_t s;
    s      = '0;
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.val  = val;
    return s;
  endfunction

  function automatic step_t item_step(input sample_t l, input sample_t r,
                                      input level_t lv, input delay_t rq);
    step_t s;
    s      = '0;
    s.kind = STEP_ITEM;
    s.it   = '{l, r, lv, rq};
    return s;
  endfunction

  function automatic step_t known_step(input sample_t l, input sample_t r,
                                       input level_t lv, input delay_t rq,
                                       input sample_t dl, input sample_t dr,
                                       input level_t al, input logic act,
                                       input delay_t dly);
    step_t s;
    s       = item_step(l, r, lv, rq);
    s.typed = 1'b1;
    s.want  = '{dl, dr, al, act, dly};
    return s;
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Requests hold for a while so that crossfades run to their end
  function automatic item_t random_item();
    item_t it;
    it.left  = pick_sample();
    it.right = pick_sample();
    it.level = level_t'($urandom);
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 3))
        0:       want_delay = delay_t'($urandom_range(0, 15));
        1:       want_delay = delay_t'($urandom);
        2:       want_delay = '0;
        default: want_delay = delay_t'(DEPTH - 1);
      endcase
    end
    it.req = want_delay;
    return it;
  endfunction

  task automatic send_item(input item_t it, input logic typed = 1'b0,
                           input result_t known = '0);
    result_t calc;
    in_if.valid           <= 1'b1;
    in_if.left_sample     <= it.left;
    in_if.right_sample    <= it.right;
    in_if.level_db        <= it.level;
    in_if.requested_delay <= it.req;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    calc = run_delay_line(it);
    delayed_q.push_back(typed ? known : calc);
  endtask

  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold input until every outstanding item has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    while (delayed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk);
  endtask

  // Random settings; phase one: shortest length, zero reciprocal; last: longest
  task automatic configure(input int ph);
    logic [LEN_W-1:0]      len;
    logic [RECIP_W-1:0]    rcp;
    logic [CFG_DATA_W-1:0] word;
    if (ph == 0) begin
      len = LEN_W'(1);
      rcp = '0;
    end else if (ph == PHASES - 1) begin
      len = '1;
      rcp = RECIP_W'($urandom);
    end else begin
      case ($urandom_range(0, 7))
        0:       len = '0;
        1:       len = LEN_W'(1);
        2:       len = LEN_W'($urandom_range(13, 200));
        default: len = LEN_W'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 5))
        0:       rcp = '0;
        1:       rcp = RECIP_W'(PROG_MAX);
        2:       rcp = '1;
        default: rcp = RECIP_W'($urandom);
      endcase
    end
    word = CFG_DATA_W'($urandom);
    word[LEN_W-1:0] = len;
    write_reg(CFG_TRANSITION_LENGTH, word);
    write_reg(CFG_TRANSITION_RECIPROCAL, rcp);
    write_reg(CFG_MONO_MODE, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
  endtask

  function automatic void compare(input string field, input logic signed [31:0] want,
                                  input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Sink side: random stall bursts
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      if (hold_cycles == 0) sink_ready <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      hold_cycles = $urandom_range(1, 6);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_out
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (delayed_q.size() == 0) begin
        $error("result accepted with no item outstanding");
        mismatches++;
      end else begin
        want = delayed_q.pop_front();
        compare("delayed_left", want.delayed_left, out_if.delayed_left);
        compare("delayed_right", want.delayed_right, out_if.delayed_right);
        compare("aligned_level_db", want.aligned_level_db, out_if.aligned_level_db);
        compare("transition_active", {31'd0, want.transition_active},
                {31'd0, out_if.transition_active});
        compare("delay_in_use", {19'd0, want.delay_in_use}, {19'd0, out_if.delay_in_use});
      end
    end
  end

  // Give up after a long stretch with no handshake on any channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.left_sample     <= '0;
    in_if.right_sample    <= '0;
    in_if.level_db        <= '0;
    in_if.requested_delay <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= '0;
    cfg_if.data           <= '0;

    foreach (ring_l[i]) begin
      ring_l[i]   = '0;
      ring_r[i]   = '0;
      ring_lvl[i] = LEVEL_RESET;
    end
    wr_ptr     = '0;
    cur_delay  = '0;
    tgt_delay  = '0;
    want_delay = '0;
    fade_left  = '0;
    fade_len   = LEN_RESET;
    recip      = RECIP_RESET;
    mono       = 1'b0;
    idle_on    = 1'b1;
    stalls_on  = 1'b1;

    // Fresh rings: delay zero returns the new pair and the reset level
    plan.push_back(known_step(24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 13'd0,
                              24'sh7FFFFF, 24'sh800000, LEVEL_RESET, 1'b0, 13'd0));
    plan.push_back(known_step(24'sh800000, 24'sh7FFFFF, 16'sh8000, 13'd0,
                              24'sh800000, 24'sh7FFFFF, LEVEL_RESET, 1'b0, 13'd0));
    // Zero length with stray upper bits, mono on, write past the register list
    plan.push_back(cfg_step(CFG_TRANSITION_LENGTH, 17'h10000));
    plan.push_back(cfg_step(CFG_TRANSITION_RECIPROCAL, 17'h10000));
    plan.push_back(cfg_step(CFG_MONO_MODE, 17'h1FFFF));
    plan.push_back(cfg_step(CFG_SPARE, 17'h1FFFF));
    // Zero length acts as one unblended item, then the new delay holds
    plan.push_back(known_step(24'sh123456, 24'sh654321, 16'sh0100, 13'd5,
                              24'sh123456, 24'sh123456, LEVEL_RESET, 1'b1, 13'd5));
    plan.push_back(known_step(24'sh0ABCDE, 24'sh7EDCBA, 16'shFF00, 13'd5,
                              24'sh000000, 24'sh000000, LEVEL_RESET, 1'b0, 13'd5));
    plan.push_back(item_step(24'shFFFFFF, 24'sh000000, 16'sh0000, 13'd0));
    // Short crossfade to the deepest tap, reciprocal at its maximum
    plan.push_back(cfg_step(CFG_TRANSITION_LENGTH, 17'd4));
    plan.push_back(cfg_step(CFG_TRANSITION_RECIPROCAL, 17'h1FFFF));
    plan.push_back(cfg_step(CFG_MONO_MODE, 17'h00000));
    plan.push_back(item_step(24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 13'd8191));
    plan.push_back(item_step(24'sh800000, 24'sh7FFFFF, 16'sh8000, 13'd8191));
    plan.push_back(item_step(24'sh555555, 24'shAAAAAA, 16'sh5555, 13'd8191));
    plan.push_back(item_step(24'shAAAAAA, 24'sh555555, 16'shAAAA, 13'd8191));
    plan.push_back(item_step(24'sh000000, 24'shFFFFFF, 16'shFFFF, 13'd8191));
    // Long crossfade, then shorten the length while it runs
    plan.push_back(cfg_step(CFG_TRANSITION_LENGTH, 17'd40));
    plan.push_back(item_step(24'sh3C3C3C, 24'shC3C3C3, 16'sh1234, 13'd2));
    plan.push_back(item_step(24'sh0F0F0F, 24'shF0F0F0, 16'shEDCB, 13'd2));
    plan.push_back(item_step(24'sh7FFFFF, 24'sh800000, 16'sh7FFF, 13'd2));
    plan.push_back(cfg_step(CFG_TRANSITION_LENGTH, 17'd3));
    plan.push_back(item_step(24'sh800000, 24'sh7FFFFF, 16'sh8000, 13'd2));
    plan.push_back(item_step(24'sh246813, 24'sh135792, 16'sh0F0F, 13'd0));
    plan.push_back(item_step(24'shFEDCBA, 24'sh012345, 16'shF0F0, 13'd2));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (plan[n]) begin
      if (plan[n].kind == STEP_CFG) begin
        drain();
        write_reg(plan[n].idx, plan[n].val);
      end else begin
        maybe_idle();
        send_item(plan[n].it, plan[n].typed, plan[n].want);
      end
    end

    // Random phases; the last one runs without gaps or stalls
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      configure(ph);
      idle_on   = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) begin
        maybe_idle();
        send_item(random_item());
      end
    end

    in_if.valid <= 1'b0;
    while (delayed_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cfdl_pkg.sv
rtl/cfdl_if.sv
rtl/cfdl_ring.sv
rtl/cfdl_blend.sv
rtl/crossfading_lookahead_delay_line_top.sv
sim/crossfading_lookahead_delay_line_top_test.sv
